FILE: hw/rtl/imdk_pkg.sv
// Shared types and codes for the indexed min-heap with decrease-key.
`timescale 1ns / 1ps
`default_nettype none
package imdk_pkg;

   localparam int NAME_BITS  = 8;
   localparam int NAME_COUNT = 256;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [1:0] ST_NEW     = 2'd0;
   localparam logic [1:0] ST_LOWERED = 2'd1;
   localparam logic [1:0] ST_KEPT    = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic        op;
      logic [7:0]  node_name;
      logic [31:0] node_score;
   } req_type;

   typedef struct packed {
      logic [7:0] popped_name;
      logic [1:0] status;
      logic [8:0] entries;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK,
      S_KEY_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_POP_RD,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/imdk_heap_ram.sv
// Heap slot memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module imdk_heap_ram #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 40,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr0,
   input  wire logic [ADDR_W-1:0] rd_addr1,
   output logic      [DATA_W-1:0] rd_data0,
   output logic      [DATA_W-1:0] rd_data1
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/imdk_pos_ram.sv
// Name-to-slot position memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module imdk_pos_ram #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 8,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/indexed_min_heap_decrease_key.sv
// Top level: indexed binary min-heap with decrease-key and its sift sequencer.
//
//   channel | ports                        | direction | transfer when
//   --------+------------------------------+-----------+-------------------
//   request | req_valid req_stall req_data | in        | valid & !stall
//   result  | rsp_valid rsp_stall rsp_data | out       | valid & !stall
//
// One item at a time; req_stall is high from acceptance until its result transfers.
// Insert: name lookup, a score check for a present name, then a parent read and compare
//   per level climbed, placement of the entry, and the result.
// Pop: fetch root and last, a child read and compare per level descended, placement of
//   the moved entry (none if it was the last), and the result; pop on empty: result only.
// Reset clears the count and all 256 name-present bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key #(
   parameter int CAPACITY   = 256,
   parameter int SCORE_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire imdk_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output imdk_pkg::rsp_type     rsp_data
);
   import imdk_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CH_W  = IDX_W + 2;
   localparam int ENT_W = NAME_BITS + SCORE_BITS;

   state_type state_ff, state_in;

   logic [NAME_BITS-1:0]  name_ff, name_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NAME_BITS-1:0]  popped_ff, popped_in;
   logic [1:0]            status_ff, status_in;
   logic [NAME_COUNT-1:0] present_ff, present_in;

   logic                  h_we;
   logic [IDX_W-1:0]      h_wa, h_ra0, h_ra1;
   logic [ENT_W-1:0]      h_wd, h_rd0, h_rd1;
   logic                  p_we;
   logic [NAME_BITS-1:0]  p_wa, p_ra;
   logic [IDX_W-1:0]      p_wd, p_rd;

   logic [SCORE_BITS+31:0] score_ext;
   logic [SCORE_BITS-1:0]  req_score;
   logic [CH_W-1:0]        left_idx, right_idx, count_ch;
   logic [IDX_W-1:0]       parent_idx, last_idx;
   logic [CNT_W-1:0]       count_dec;
   logic [CNT_W+8:0]       entries_ext;
   logic                   take_left, take_right;
   logic [SCORE_BITS-1:0]  best_score;

   imdk_heap_ram #(
      .DEPTH(CAPACITY), .DATA_W(ENT_W), .ADDR_W(IDX_W)
   ) u_heap (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_wa),
      .wr_data (h_wd),
      .rd_addr0(h_ra0),
      .rd_addr1(h_ra1),
      .rd_data0(h_rd0),
      .rd_data1(h_rd1)
   );

   imdk_pos_ram #(
      .DEPTH(NAME_COUNT), .DATA_W(IDX_W), .ADDR_W(NAME_BITS)
   ) u_pos (
      .clock  (clock),
      .wr_en  (p_we),
      .wr_addr(p_wa),
      .wr_data(p_wd),
      .rd_addr(p_ra),
      .rd_data(p_rd)
   );

   assign score_ext  = {{SCORE_BITS{1'b0}}, req_data.node_score};
   assign req_score  = score_ext[SCORE_BITS-1:0];
   assign left_idx   = {1'b0, k_ff, 1'b1};
   assign right_idx  = {1'b0, k_ff, 1'b0} + CH_W'(2);
   assign count_ch   = CH_W'(count_ff);
   assign parent_idx = (k_ff - IDX_W'(1)) >> 1;
   assign count_dec  = count_ff - CNT_W'(1);
   assign last_idx   = count_dec[IDX_W-1:0];

   // Sift-down compare: pick the smaller child against the moving entry.
   always_comb begin
      take_left  = (left_idx < count_ch) &&
                   (h_rd0[SCORE_BITS-1:0] < score_ff);
      best_score = take_left ? h_rd0[SCORE_BITS-1:0] : score_ff;
      take_right = (right_idx < count_ch) &&
                   (h_rd1[SCORE_BITS-1:0] < best_score);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_POP) begin
                  state_in = (count_ff == '0) ? S_DONE : S_POP_RD;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (!present_ff[name_ff]) begin
               state_in = (count_ff == CNT_W'(CAPACITY)) ? S_DONE : S_UP_RD;
            end else begin
               state_in = S_KEY_CMP;
            end
         end
         S_KEY_CMP: state_in = (score_ff < h_rd0[SCORE_BITS-1:0]) ? S_UP_RD : S_DONE;
         S_UP_RD:   state_in = (k_ff == '0) ? S_DONE : S_UP_CMP;
         S_UP_CMP:  state_in = (score_ff < h_rd0[SCORE_BITS-1:0]) ? S_UP_RD : S_DONE;
         S_POP_RD:  state_in = (count_ff == CNT_W'(1)) ? S_DONE : S_DN_RD;
         S_DN_RD:   state_in = (left_idx < count_ch) ? S_DN_CMP : S_DONE;
         S_DN_CMP:  state_in = (take_left || take_right) ? S_DN_RD : S_DONE;
         S_DONE:    state_in = rsp_stall ? S_DONE : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      name_in    = name_ff;
      score_in   = score_ff;
      k_in       = k_ff;
      count_in   = count_ff;
      popped_in  = popped_ff;
      status_in  = status_ff;
      present_in = present_ff;
      h_we  = 1'b0;
      h_wa  = k_ff;
      h_wd  = {name_ff, score_ff};
      h_ra0 = k_ff;
      h_ra1 = last_idx;
      p_we  = 1'b0;
      p_wa  = name_ff;
      p_wd  = k_ff;
      p_ra  = req_data.node_name;
      unique case (state_ff)
         S_IDLE: begin
            name_in   = req_data.node_name;
            score_in  = req_score;
            popped_in = '0;
            status_in = ST_EMPTY;
            h_ra0     = '0;
         end
         S_LOOK: begin
            if (!present_ff[name_ff]) begin
               status_in = ST_KEPT;
               if (count_ff != CNT_W'(CAPACITY)) begin
                  status_in           = ST_NEW;
                  k_in                = count_ff[IDX_W-1:0];
                  count_in            = count_ff + CNT_W'(1);
                  present_in[name_ff] = 1'b1;
               end
            end else begin
               k_in  = p_rd;
               h_ra0 = p_rd;
            end
         end
         S_KEY_CMP: begin
            status_in = (score_ff < h_rd0[SCORE_BITS-1:0]) ? ST_LOWERED : ST_KEPT;
         end
         S_UP_RD: begin
            h_ra0 = parent_idx;
            if (k_ff == '0) begin
               h_we = 1'b1;
               p_we = 1'b1;
            end
         end
         S_UP_CMP: begin
            if (score_ff < h_rd0[SCORE_BITS-1:0]) begin
               // move parent down into the hole, climb
               h_we = 1'b1;
               h_wd = h_rd0;
               p_we = 1'b1;
               p_wa = h_rd0[ENT_W-1:SCORE_BITS];
               k_in = parent_idx;
            end else begin
               h_we = 1'b1;
               p_we = 1'b1;
            end
         end
         S_POP_RD: begin
            popped_in = h_rd0[ENT_W-1:SCORE_BITS];
            status_in = ST_NEW;
            present_in[h_rd0[ENT_W-1:SCORE_BITS]] = 1'b0;
            count_in  = count_dec;
            name_in   = h_rd1[ENT_W-1:SCORE_BITS];
            score_in  = h_rd1[SCORE_BITS-1:0];
            k_in      = '0;
         end
         S_DN_RD: begin
            h_ra0 = left_idx[IDX_W-1:0];
            h_ra1 = right_idx[IDX_W-1:0];
            if (!(left_idx < count_ch)) begin
               h_we = 1'b1;
               p_we = 1'b1;
            end
         end
         S_DN_CMP: begin
            h_we = 1'b1;
            p_we = 1'b1;
            if (take_right) begin
               h_wd = h_rd1;
               p_wa = h_rd1[ENT_W-1:SCORE_BITS];
               k_in = right_idx[IDX_W-1:0];
            end else if (take_left) begin
               h_wd = h_rd0;
               p_wa = h_rd0[ENT_W-1:SCORE_BITS];
               k_in = left_idx[IDX_W-1:0];
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         present_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff   <= name_in;
      score_ff  <= score_in;
      k_ff      <= k_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign entries_ext          = {9'b0, count_ff};
   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = (state_ff == S_DONE);
   assign rsp_data.popped_name = popped_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.entries     = entries_ext[8:0];

endmodule
`default_nettype wire
